// ===== rtl/core/dart_pkg.sv =====
// Shared types, codes and period table for the prescaled reload timer.
package dart_pkg;

  localparam int PRE_W = 12;

  // Item kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register addresses
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  localparam logic [PRE_W-1:0] DIV_PERIOD = 12'd256;
  localparam logic [PRE_W-1:0] CNT_RESET  = 12'd1024;
  localparam int CTRL_EN_BIT = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic [7:0] elapsed_cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } result_t;

  // Counter reload period selected by control bits 1:0
  function automatic logic [PRE_W-1:0] cnt_period(input logic [1:0] sel);
    logic [PRE_W-1:0] p;
    case (sel)
      2'd0:    p = 12'd1024;
      2'd1:    p = 12'd16;
      2'd2:    p = 12'd64;
      default: p = 12'd256;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/dart_core.sv =====
// Timer registers, prescalers and per-item next-state logic.
`default_nettype none
module dart_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire dart_pkg::item_t item,
  output dart_pkg::result_t    result
);
  import dart_pkg::*;

  logic [PRE_W-1:0] div_pre_r, div_pre_nxt;
  logic [PRE_W-1:0] cnt_pre_r, cnt_pre_nxt;
  logic [7:0]       divider_r, divider_nxt;
  logic [7:0]       counter_r, counter_nxt;
  logic [7:0]       modulo_r, modulo_nxt;
  logic [7:0]       control_r, control_nxt;

  logic [PRE_W-1:0] n;
  logic             div_exp, cnt_exp;

  assign n       = {{(PRE_W-8){1'b0}}, item.elapsed_cycles};
  assign div_exp = (div_pre_r <= n);
  assign cnt_exp = (cnt_pre_r <= n);

  // Compute next state and the result for the item in flight
  always_comb begin
    div_pre_nxt = div_pre_r;
    cnt_pre_nxt = cnt_pre_r;
    divider_nxt = divider_r;
    counter_nxt = counter_r;
    modulo_nxt  = modulo_r;
    control_nxt = control_r;
    result      = '0;
    unique case (item.op)
      OP_TICK: begin
        if (div_exp) begin
          div_pre_nxt = DIV_PERIOD;
          divider_nxt = divider_r + 8'd1;
        end else begin
          div_pre_nxt = div_pre_r - n;
        end
        if (control_r[CTRL_EN_BIT]) begin
          if (cnt_exp) begin
            cnt_pre_nxt = cnt_period(control_r[1:0]);
            if (counter_r == 8'hFF) begin
              counter_nxt      = modulo_r;
              result.timer_irq = 1'b1;
            end else begin
              counter_nxt = counter_r + 8'd1;
            end
          end else begin
            cnt_pre_nxt = cnt_pre_r - n;
          end
        end
      end
      OP_READ: begin
        unique case (item.reg_sel)
          REG_DIV:  result.read_data = divider_r;
          REG_CNT:  result.read_data = counter_r;
          REG_MOD:  result.read_data = modulo_r;
          default:  result.read_data = control_r;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_sel)
          REG_DIV:  divider_nxt = item.write_data;
          REG_CNT:  counter_nxt = item.write_data;
          REG_MOD:  modulo_nxt  = item.write_data;
          default:  control_nxt = item.write_data;
        endcase
      end
      default: ;  // unused kind: no effect
    endcase
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pre_r <= DIV_PERIOD;
      cnt_pre_r <= CNT_RESET;
      divider_r <= '0;
      counter_r <= '0;
      modulo_r  <= '0;
      control_r <= '0;
    end else if (fire) begin
      div_pre_r <= div_pre_nxt;
      cnt_pre_r <= cnt_pre_nxt;
      divider_r <= divider_nxt;
      counter_r <= counter_nxt;
      modulo_r  <= modulo_nxt;
      control_r <= control_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/divider_and_reload_timer.sv =====
// Top level of the prescaled timer with modulo reload: input and result registers.
//
//   channel | direction | tdata                           | tuser
//   in_     | slave     | [7:0] write_data, [15:8] cycles | [1:0] op, [3:2] reg_sel
//   out_    | master    | [7:0] read_data, [8] timer_irq  | -
//
// Every item yields one result; one item per cycle is sustained while the output
// takes each result, and an item passes the input register, then the result register
// (the timer state updates as the item enters the result register).
// Reset (rst_n low, synchronous) empties both registers and restores the timer.
// A stalled output holds its result; the input register keeps taking items
// while it is free or draining.
`default_nettype none
module divider_and_reload_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] write_data, [15:8] elapsed_cycles
  input  wire logic [3:0]  in_tuser,   // [1:0] op, [3:2] reg_sel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [7:0] read_data, [8] timer_irq, [15:9] zero
);
  import dart_pkg::*;

  logic    s1_v_r;
  item_t   s1_r;
  logic    out_v_r;
  result_t out_r;
  result_t res;
  logic    adv_out;

  assign adv_out   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv_out;

  dart_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv_out),
    .item   (s1_r),
    .result (res)
  );

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r.op             <= in_tuser[1:0];
      s1_r.reg_sel        <= in_tuser[3:2];
      s1_r.write_data     <= in_tdata[7:0];
      s1_r.elapsed_cycles <= in_tdata[15:8];
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.timer_irq, out_r.read_data};

endmodule
`default_nettype wire

// ===== tb/timer_check_pkg.sv =====
// Scoreboard class that predicts the timer's results and checks each result transfer.
package timer_check_pkg;
  import dart_pkg::*;

  // Item kind that the timer ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_PRINTED = 50;

  class timer_scoreboard;
    logic [PRE_W-1:0] div_count;
    logic [PRE_W-1:0] cnt_count;
    logic [7:0] divider;
    logic [7:0] counter;
    logic [7:0] modulo;
    logic [7:0] control;
    logic [PRE_W-1:0] cnt_reload [4];
    result_t expected_replies [$];
    int failures;

    function new();
      cnt_reload = '{12'd1024, 12'd16, 12'd64, 12'd256};
      div_count = DIV_PERIOD;
      cnt_count = CNT_RESET;
      divider = 8'h00;
      counter = 8'h00;
      modulo = 8'h00;
      control = 8'h00;
      failures = 0;
    endfunction

    // Drop a prescale count by n; reload it and flag expiry once it hits zero or below
    function bit expire(inout logic [PRE_W-1:0] count, input logic [7:0] n,
                        input logic [PRE_W-1:0] reload);
      if (count <= {4'h0, n}) begin
        count = reload;
        return 1'b1;
      end
      count = count - {4'h0, n};
      return 1'b0;
    endfunction

    // Advance both prescalers by n machine cycles; return the overflow pulse
    function logic run_tick(input logic [7:0] n);
      logic irq;
      irq = 1'b0;
      if (expire(div_count, n, DIV_PERIOD))
        divider = divider + 8'd1;
      if (control[CTRL_EN_BIT]) begin
        if (expire(cnt_count, n, cnt_reload[control[1:0]])) begin
          if (counter == 8'hFF) begin
            counter = modulo;
            irq = 1'b1;
          end else begin
            counter = counter + 8'd1;
          end
        end
      end
      return irq;
    endfunction

    // Apply an accepted input transfer and queue the result it causes
    function void note_transfer(input item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OP_TICK: r.timer_irq = run_tick(it.elapsed_cycles);
        OP_READ: begin
          case (it.reg_sel)
            REG_DIV: r.read_data = divider;
            REG_CNT: r.read_data = counter;
            REG_MOD: r.read_data = modulo;
            default: r.read_data = control;
          endcase
        end
        OP_WRITE: begin
          case (it.reg_sel)
            REG_DIV: divider = it.write_data;
            REG_CNT: counter = it.write_data;
            REG_MOD: modulo = it.write_data;
            default: control = it.write_data;
          endcase
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report_mismatch(input string what);
      failures++;
      if (failures <= MAX_PRINTED)
        $display("mismatch: %s", what);
    endtask

    // Compare a result transfer with the oldest queued result
    task check_transfer(input logic [15:0] tdata);
      result_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing queued", tdata));
        return;
      end
      want = expected_replies.pop_front();
      if (tdata[7:0] !== want.read_data)
        report_mismatch($sformatf("read_data got %h want %h", tdata[7:0], want.read_data));
      if (tdata[8] !== want.timer_irq)
        report_mismatch($sformatf("timer_irq got %b want %b", tdata[8], want.timer_irq));
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench: drives tick, read and write transfers into the timer and checks results.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dart_pkg::*;
  import timer_check_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_TOGGLE} ready_pattern_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;

  timer_scoreboard sb = new();

  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  int quiet_cycles = 0;
  ready_pattern_e ready_mode = RDY_ALWAYS;

  always #1 clk = ~clk;

  divider_and_reload_timer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Receive results; stall on a changing pattern and serve long hold-off requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_transfer(out_tdata);
      if (hold_left == 0 && hold_requests != holds_served) begin
        holds_served = holds_served + 1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        ready_mode = ready_pattern_e'($urandom_range(0, 3));
      end else begin
        mode_left = mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // End the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer happens
  task automatic send_item(input item_t it);
    in_tvalid <= 1'b1;
    in_tdata <= {it.elapsed_cycles, it.write_data};
    in_tuser <= {it.reg_sel, it.op};
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(it);
  endtask

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender until every queued result has come back
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly ticks, with writes biased toward enabled control and a counter near wrap
  function automatic item_t random_item();
    item_t it;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    it.reg_sel = 2'($urandom_range(0, 3));
    it.write_data = 8'($urandom_range(0, 255));
    it.elapsed_cycles = 8'($urandom_range(0, 255));
    if (pick < 50) begin
      it.op = OP_TICK;
      if (span == 0)
        it.elapsed_cycles = 8'h00;
      else if (span < 4)
        it.elapsed_cycles = 8'($urandom_range(1, 20));
    end else if (pick < 68) begin
      it.op = OP_READ;
    end else if (pick < 94) begin
      it.op = OP_WRITE;
      if (it.reg_sel == REG_CTRL)
        it.write_data[CTRL_EN_BIT] = ($urandom_range(0, 3) != 0);
      else if (it.reg_sel == REG_CNT && span < 5)
        it.write_data = 8'($urandom_range(240, 255));
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Send random items in bursts of random length with random gaps
  task automatic run_random(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 4) != 0)
        pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of all registers
    send_item('{OP_READ, REG_DIV, 8'h00, 8'h00});
    send_item('{OP_READ, REG_CNT, 8'h00, 8'h00});
    send_item('{OP_READ, REG_MOD, 8'h00, 8'h00});
    send_item('{OP_READ, REG_CTRL, 8'h00, 8'h00});
    // Zero-cycle tick, then the divider expiring exactly at zero
    send_item('{OP_TICK, REG_DIV, 8'h00, 8'h00});
    send_item('{OP_TICK, REG_DIV, 8'h00, 8'hFF});
    send_item('{OP_TICK, REG_DIV, 8'h00, 8'h01});
    // Counter at the top, full control byte; prescale keeps its old count
    send_item('{OP_WRITE, REG_MOD, 8'hFF, 8'h00});
    send_item('{OP_WRITE, REG_CNT, 8'hFF, 8'h00});
    send_item('{OP_WRITE, REG_CTRL, 8'hFF, 8'h00});
    send_item('{OP_READ, REG_CTRL, 8'h00, 8'h00});
    repeat (4) send_item('{OP_TICK, REG_CNT, 8'h00, 8'hFF});
    send_item('{OP_TICK, REG_CNT, 8'h00, 8'h04});
    send_item('{OP_READ, REG_CNT, 8'h00, 8'h00});
    // Second wrap straight from the modulo value
    send_item('{OP_TICK, REG_CNT, 8'h00, 8'hFF});
    send_item('{OP_TICK, REG_CNT, 8'h00, 8'h01});
    // Divider write, counter disabled, unused kind
    send_item('{OP_WRITE, REG_DIV, 8'h00, 8'hFF});
    send_item('{OP_WRITE, REG_CTRL, 8'h00, 8'hFF});
    send_item('{OP_TICK, REG_CTRL, 8'hFF, 8'hFF});
    send_item('{OP_READ, REG_CNT, 8'hFF, 8'hFF});
    send_item('{OP_UNUSED, REG_CTRL, 8'hFF, 8'hFF});
    send_item('{OP_READ, REG_DIV, 8'h00, 8'h00});
    wait_for_drain();

    run_random(400);
    wait_for_drain();
    // Receiver holds off while the sender keeps offering
    hold_requests <= hold_requests + 1;
    run_random(400);
    wait_for_drain();
    run_random(425);
    wait_for_drain();
    run_random(400);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
